// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the UART register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_RESET(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_RESET(label, prop, msg)

`endif

`endif

// ----- src/urbf_pkg.sv -----
// Types, constants and helper functions of the UART register block with FIFOs.
`default_nettype none

package urbf_pkg;

  localparam int QUEUE_SLOTS = 8;
  localparam int REG_BYTES   = 32;

  localparam int QIDX_W    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int FILL_W    = $clog2(QUEUE_SLOTS + 1);
  localparam int REG_IDX_W = $clog2(REG_BYTES);

  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_LINE_RX = 2'd2,
    MODE_TX_TAKE = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_CLOCK_ENABLE = 1'b0,
    CFG_FIFO_DEPTH   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  offset;
    logic [2:0]  access_size;
    logic [7:0]  write_data;
    logic [7:0]  line_byte;
    logic [7:0]  line_errors;
    logic        shifter_busy;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] flags;
  } entry_t;

  localparam logic [2:0] ACCESS_BYTE     = 3'd1;
  localparam logic [3:0] FIFO_DEPTH_RESET = 4'd8;

  // register byte offsets
  localparam reg_idx_t OFS_S1     = reg_idx_t'(4);
  localparam reg_idx_t OFS_S2     = reg_idx_t'(5);
  localparam reg_idx_t OFS_D      = reg_idx_t'(7);
  localparam reg_idx_t OFS_ED     = reg_idx_t'(12);
  localparam reg_idx_t OFS_PFIFO  = reg_idx_t'(16);
  localparam reg_idx_t OFS_CFIFO  = reg_idx_t'(17);
  localparam reg_idx_t OFS_SFIFO  = reg_idx_t'(18);
  localparam reg_idx_t OFS_TCFIFO = reg_idx_t'(20);
  localparam reg_idx_t OFS_RCFIFO = reg_idx_t'(22);

  // bit masks
  localparam logic [7:0] S1_STICKY     = 8'h1f;
  localparam logic [7:0] S1_RDRF       = 8'h20;
  localparam logic [7:0] S1_TDRE       = 8'h80;
  localparam logic [7:0] S1_TC         = 8'h40;
  localparam logic [7:0] S1_KEEP_ON_D  = 8'hf0;
  localparam logic [7:0] ERR_NIBBLE    = 8'h0f;
  localparam logic [7:0] S2_W1C        = 8'hc0;
  localparam logic [7:0] S2_RW         = 8'h3f;
  localparam logic [7:0] CFIFO_STORED  = 8'h0c;
  localparam logic [7:0] CFIFO_RXFLUSH = 8'h40;
  localparam logic [7:0] CFIFO_TXFLUSH = 8'h80;
  localparam logic [7:0] SFIFO_W1C     = 8'hc3;
  localparam logic [7:0] SFIFO_TXOF    = 8'h02;
  localparam logic [7:0] PFIFO_KEEP    = 8'h77;
  localparam logic [7:0] PFIFO_RW      = 8'h88;
  localparam logic [7:0] PFIFO_RXFE    = 8'h08;
  localparam logic [7:0] PFIFO_TXFE    = 8'h80;

  // Usable entries: one with the FIFO disabled, else the depth, clipped to the storage.
  function automatic fill_t queue_cap(input logic enabled, input logic [3:0] depth);
    fill_t cap;
    if (!enabled) begin
      cap = fill_t'(1);
    end else if (int'(depth) > QUEUE_SLOTS) begin
      cap = fill_t'(QUEUE_SLOTS);
    end else begin
      cap = fill_t'(depth);
    end
    return cap;
  endfunction

  function automatic logic [7:0] refresh_s1(input logic [7:0] s1, input logic rx_any,
                                            input logic [7:0] rx_flags, input logic tx_room,
                                            input logic tx_done);
    logic [7:0] s;
    s = s1 & S1_STICKY;
    if (rx_any) begin
      s = s | S1_RDRF | (rx_flags & ERR_NIBBLE);
    end
    if (tx_room) begin
      s = s | S1_TDRE;
    end
    if (tx_done) begin
      s = s | S1_TC;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/urbf_fifo.sv -----
// Shifting FIFO: the head sits in slot 0 and the entry behind it in slot 1.
`default_nettype none

module urbf_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic            pop,
  input  wire logic            flush,
  input  wire urbf_pkg::entry_t push_entry,
  output urbf_pkg::entry_t     head,
  output urbf_pkg::entry_t     second,
  output urbf_pkg::fill_t      fill
);
  import urbf_pkg::*;

  entry_t            slots [QUEUE_SLOTS];
  fill_t             fill_next;
  logic [QIDX_W-1:0] tail_idx;

  assign tail_idx = fill[QIDX_W-1:0];
  assign head     = slots[0];

  // push and pop never come in the same cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
        slots[i] <= slots[i + 1];
      end
    end else if (push) begin
      slots[tail_idx] <= push_entry;
    end
  end

  if (QUEUE_SLOTS > 1) begin : g_second
    assign second = slots[1];
  end else begin : g_no_second
    assign second = slots[0];
  end

  always_comb begin
    fill_next = fill;
    if (flush) begin
      fill_next = '0;
    end else if (push) begin
      fill_next = fill + fill_t'(1);
    end else if (pop) begin
      fill_next = fill - fill_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/uart_register_block_with_fifos.sv -----
// Top level: UART register file with receive and transmit FIFOs.
//
// One item (bus read, bus write, received line byte or transmitter pop) is
// taken on every clock in which start is high; busy never rises. Each item
// passes an input register and then the state update and result register,
// so its result is on result with done high once it has passed both
// registers; one result per item, in order. done lasts one cycle and the
// receiver cannot stall it.
// Configuration writes through cfg_we take effect at once and belong to idle
// periods.
`default_nettype none

`include "assert_macros.svh"

module uart_register_block_with_fifos (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire urbf_pkg::item_t   item,
  output logic                   done,
  output urbf_pkg::result_t      result,
  input  wire logic              cfg_we,
  input  wire urbf_pkg::cfg_index_t cfg_index,
  input  wire logic [3:0]        cfg_data
);
  import urbf_pkg::*;

  // configuration
  logic       clock_enable;
  logic [3:0] depth_cfg;

  // input register
  logic  valid_q;
  item_t item_q;

  // result register
  logic    done_q;
  result_t result_q;
  result_t result_next;

  // register file and status latch
  logic [7:0] regs      [REG_BYTES];
  logic [7:0] regs_next [REG_BYTES];
  logic       s1_was_read;
  logic       s1_was_read_next;

  // FIFOs
  logic   rx_push, rx_pop, rx_flush;
  logic   tx_push, tx_pop, tx_flush;
  entry_t rx_head, rx_second, tx_head, tx_second, tx_entry, rx_entry;
  fill_t  rx_fill, tx_fill;
  fill_t  rx_cap, tx_cap, tx_cap_w;
  fill_t  rx_fill_d, rx_fill_w, tx_fill_w;

  logic       bus_ok;
  logic       bus_refused;
  logic       bus_write;
  logic       tx_idle;
  reg_idx_t   ofs_idx;
  logic [7:0] s1_pre, s1_mid;
  logic [7:0] wv;

  assign busy = 1'b0;
  assign done = done_q;
  assign result = result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_enable <= 1'b0;
      depth_cfg    <= FIFO_DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_ENABLE: clock_enable <= cfg_data[0];
        CFG_FIFO_DEPTH:   depth_cfg    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
  end

  assign ofs_idx  = reg_idx_t'(item_q.offset);
  assign wv       = item_q.write_data;
  assign bus_ok   = clock_enable && item_q.access_size == ACCESS_BYTE &&
                    int'(item_q.offset) < REG_BYTES;
  assign bus_refused = valid_q && !bus_ok &&
                       (item_q.mode == MODE_READ || item_q.mode == MODE_WRITE);
  assign bus_write   = valid_q && bus_ok && item_q.mode == MODE_WRITE;
  assign tx_idle  = tx_fill == '0 && !item_q.shifter_busy;
  assign rx_cap   = queue_cap((regs[OFS_PFIFO] & PFIFO_RXFE) != '0, depth_cfg);
  assign tx_cap   = queue_cap((regs[OFS_PFIFO] & PFIFO_TXFE) != '0, depth_cfg);
  assign s1_pre   = refresh_s1(regs[OFS_S1], rx_fill != '0, rx_head.flags,
                               tx_fill < tx_cap, tx_idle);
  assign rx_entry = '{data: item_q.line_byte, flags: item_q.line_errors};
  assign tx_entry = '{data: wv, flags: '0};

  always_comb begin
    regs_next        = regs;
    s1_was_read_next = s1_was_read;
    result_next      = '0;
    rx_push  = 1'b0;
    rx_pop   = 1'b0;
    rx_flush = 1'b0;
    tx_push  = 1'b0;
    tx_pop   = 1'b0;
    tx_flush = 1'b0;
    s1_mid    = s1_pre;
    rx_fill_d = rx_fill;
    rx_fill_w = rx_fill;
    tx_fill_w = tx_fill;
    tx_cap_w  = tx_cap;
    if (valid_q) begin
      case (item_q.mode)
        MODE_LINE_RX: begin
          if (rx_fill < rx_cap) begin
            rx_push              = 1'b1;
            result_next.accepted = 1'b1;
          end
        end
        MODE_TX_TAKE: begin
          if (tx_fill != '0) begin
            tx_pop               = 1'b1;
            result_next.accepted = 1'b1;
            result_next.tx_valid = 1'b1;
            result_next.tx_byte  = tx_head.data;
          end
        end
        MODE_READ: begin
          if (bus_ok) begin
            result_next.accepted = 1'b1;
            regs_next[OFS_S1]     = s1_pre;
            regs_next[OFS_RCFIFO] = 8'(rx_fill);
            regs_next[OFS_TCFIFO] = 8'(tx_fill);
            if (ofs_idx == OFS_S1) begin
              s1_was_read_next = 1'b1;
            end
            if (ofs_idx == OFS_D) begin
              if (rx_fill != '0) begin
                result_next.read_data = rx_head.data;
                regs_next[OFS_ED]     = rx_head.flags;
                rx_pop                = 1'b1;
                rx_fill_d             = rx_fill - fill_t'(1);
              end else begin
                result_next.read_data = regs[OFS_D];
              end
              // an S1 read followed by a D read clears the error flags
              if (s1_was_read) begin
                s1_mid = s1_pre & S1_KEEP_ON_D;
              end
              s1_was_read_next = 1'b0;
              regs_next[OFS_S1] = refresh_s1(s1_mid, rx_fill_d != '0,
                                             rx_pop ? rx_second.flags : rx_head.flags,
                                             tx_fill < tx_cap, tx_idle);
              regs_next[OFS_RCFIFO] = 8'(rx_fill_d);
            end else if (ofs_idx == OFS_S1) begin
              result_next.read_data = s1_pre;
            end else if (ofs_idx == OFS_RCFIFO) begin
              result_next.read_data = 8'(rx_fill);
            end else if (ofs_idx == OFS_TCFIFO) begin
              result_next.read_data = 8'(tx_fill);
            end else begin
              result_next.read_data = regs[ofs_idx];
            end
          end
        end
        MODE_WRITE: begin
          if (bus_ok) begin
            result_next.accepted = 1'b1;
            case (ofs_idx)
              OFS_S1: regs_next[OFS_S1] = regs[OFS_S1] & ~(wv & S1_STICKY);
              OFS_S2: regs_next[OFS_S2] = (regs[OFS_S2] & ~(wv & S2_W1C) & S2_W1C) |
                                          (wv & S2_RW);
              OFS_D: begin
                if (tx_fill < tx_cap) begin
                  tx_push = 1'b1;
                end else begin
                  regs_next[OFS_SFIFO] = regs[OFS_SFIFO] | SFIFO_TXOF;
                end
              end
              OFS_CFIFO: begin
                rx_flush = (wv & CFIFO_RXFLUSH) != '0;
                tx_flush = (wv & CFIFO_TXFLUSH) != '0;
                regs_next[OFS_CFIFO] = wv & CFIFO_STORED;
              end
              OFS_SFIFO: regs_next[OFS_SFIFO] = regs[OFS_SFIFO] & ~(wv & SFIFO_W1C);
              OFS_PFIFO: regs_next[OFS_PFIFO] = (regs[OFS_PFIFO] & PFIFO_KEEP) |
                                                (wv & PFIFO_RW);
              OFS_ED, OFS_TCFIFO, OFS_RCFIFO: ;
              default: regs_next[ofs_idx] = wv;
            endcase
            rx_fill_w = rx_flush ? '0 : rx_fill;
            tx_fill_w = tx_flush ? '0 : tx_fill + fill_t'(tx_push);
            tx_cap_w  = queue_cap((regs_next[OFS_PFIFO] & PFIFO_TXFE) != '0, depth_cfg);
            regs_next[OFS_S1] = refresh_s1(regs_next[OFS_S1], rx_fill_w != '0,
                                           rx_head.flags, tx_fill_w < tx_cap_w,
                                           tx_fill_w == '0 && !item_q.shifter_busy);
            regs_next[OFS_RCFIFO] = 8'(rx_fill_w);
            regs_next[OFS_TCFIFO] = 8'(tx_fill_w);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_BYTES; i++) begin
        regs[i] <= '0;
      end
      s1_was_read <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      regs        <= regs_next;
      s1_was_read <= s1_was_read_next;
      done_q      <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_q) begin
      result_q <= result_next;
    end
  end

  urbf_fifo u_rx_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (rx_push),
    .pop        (rx_pop),
    .flush      (rx_flush),
    .push_entry (rx_entry),
    .head       (rx_head),
    .second     (rx_second),
    .fill       (rx_fill)
  );

  urbf_fifo u_tx_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (tx_push),
    .pop        (tx_pop),
    .flush      (tx_flush),
    .push_entry (tx_entry),
    .head       (tx_head),
    .second     (tx_second),
    .fill       (tx_fill)
  );

  `ASSERT_RESET(a_no_done_after_reset, rst |=> !done, "done raised after reset")
  `ASSERT_ALWAYS(a_tx_acc, done && result.tx_valid |-> result.accepted, "lone tx_valid")
  `ASSERT_ALWAYS(a_refused, bus_refused |=> $stable({rx_fill, tx_fill}), "FIFO moved")
  `ASSERT_ALWAYS(a_tdre, bus_write |=> regs[OFS_S1][7] == (tx_fill < tx_cap), "TDRE out of step")
  `ASSERT_ALWAYS(a_rx_push, rx_push |=> rx_fill == $past(rx_fill) + 1'b1, "rx push lost")
  `ASSERT_ALWAYS(a_tx_pop, tx_pop && tx_fill > 4'd1 |=> tx_head == $past(tx_second), "tx shift")

endmodule

`default_nettype wire
